### rtl/core/bsp_pkg.sv
`timescale 1ns / 1ps
package bsp_pkg;

    localparam int DivW  = 48;
    localparam int QBits = 17;
    localparam int WideW = DivW + QBits;

    typedef logic [DivW-1:0]  t_mag;
    typedef logic [WideW-1:0] t_wide;
    typedef logic [QBits-1:0] t_quot;

    typedef enum logic [2:0] {
        REG_PLAYER_X  = 3'd0,
        REG_PLAYER_Y  = 3'd1,
        REG_DIR_X     = 3'd2,
        REG_DIR_Y     = 3'd3,
        REG_PLANE_X   = 3'd4,
        REG_PLANE_Y   = 3'd5,
        REG_SCREEN_W  = 3'd6,
        REG_SCREEN_H  = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic valid;
        logic zero;
        logic front;
    } t_side;

endpackage

### rtl/core/bsp_div.sv
`timescale 1ns / 1ps
module bsp_div (
    input  logic                i_clk,
    input  bsp_pkg::t_mag       i_num,
    input  bsp_pkg::t_mag       i_den,
    input  logic                i_neg,
    output logic signed [15:0]  o_quot
);
    import bsp_pkg::*;

    t_mag  r_rem [0:QBits];
    t_mag  r_den [0:QBits];
    t_quot r_q   [0:QBits];
    logic  r_neg [0:QBits];
    logic  r_ovf [0:QBits];

    t_wide n_sub  [0:QBits-1];
    logic  n_take [0:QBits-1];
    t_mag  n_rem  [0:QBits-1];
    t_quot n_q    [0:QBits-1];

    always_comb begin
        for (int i = 0; i < QBits; i++) begin
            n_sub[i]  = {QBits'(0), r_den[i]} << (QBits - 1 - i);
            n_take[i] = ({QBits'(0), r_rem[i]} >= n_sub[i]);
            n_rem[i]  = n_take[i] ? (r_rem[i] - n_sub[i][DivW-1:0]) : r_rem[i];
            n_q[i]    = n_take[i] ? (r_q[i] | (t_quot'(1) << (QBits - 1 - i))) : r_q[i];
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0] <= i_num;
        r_den[0] <= i_den;
        r_q[0]   <= '0;
        r_neg[0] <= i_neg;
        r_ovf[0] <= ({QBits'(0), i_num} >= {i_den, QBits'(0)});
        for (int i = 0; i < QBits; i++) begin
            r_rem[i+1] <= n_rem[i];
            r_den[i+1] <= r_den[i];
            r_q[i+1]   <= n_q[i];
            r_neg[i+1] <= r_neg[i];
            r_ovf[i+1] <= r_ovf[i];
        end
    end

    always_comb begin
        if (r_neg[QBits]) begin
            if (r_ovf[QBits] || r_q[QBits] > QBits'(32768)) begin
                o_quot = -16'sd32768;
            end else begin
                o_quot = 16'(-$signed({1'b0, r_q[QBits]}));
            end
        end else begin
            if (r_ovf[QBits] || r_q[QBits] > QBits'(32767)) begin
                o_quot = 16'sd32767;
            end else begin
                o_quot = $signed(r_q[QBits][15:0]);
            end
        end
    end

endmodule

### rtl/core/billboard_sprite_projection.sv
`timescale 1ns / 1ps
// An accepted start passes through r_v1 to r_v4, the r_side chain and o_valid to its item's strobe.
// Throughput: one item per cycle; busy is always low.
// Most of that path lies in the four 17-step restoring dividers, one quotient bit a stage.
// Reset (synchronous, active low) clears the configuration to its defaults and all
// valid bits; the receiver cannot stall, so each result shows for one cycle only.
module billboard_sprite_projection (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] i_obj_x,
    input  logic signed [15:0] i_obj_y,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    output logic               o_valid,
    output logic signed [15:0] o_center_col,
    output logic signed [15:0] o_depth,
    output logic signed [15:0] o_vert_shift,
    output logic [14:0]        o_sprite_size,
    output logic [11:0]        o_top_row,
    output logic [11:0]        o_bottom_row,
    output logic [11:0]        o_left_col,
    output logic [11:0]        o_right_col,
    output logic signed [15:0] o_left_edge,
    output logic               o_in_front
);
    import bsp_pkg::*;

    logic signed [15:0] r_px, r_py, r_dirx, r_diry, r_plx, r_ply;
    logic [12:0]        r_w, r_h;

    logic               r_v1, r_v2, r_v3, r_v4;
    logic signed [16:0] r1_dx, r1_dy;
    logic signed [32:0] r2_pa, r2_pb, r2_pc, r2_pd;
    logic signed [31:0] r2_da, r2_db;
    logic signed [33:0] r3_nx, r3_ny;
    logic signed [32:0] r3_det;
    logic signed [47:0] r4_dnum, r4_cnum, r4_hd, r4_ny640, r4_ny64, r4_det, r4_ny;
    logic               r4_zero;

    t_side r_side [0:QBits];

    logic signed [15:0] n_qd, n_qc, n_qv, n_qs;
    logic               n_front;

    function automatic t_mag f_abs(input logic signed [47:0] v);
        f_abs = v[47] ? t_mag'(-v) : t_mag'(v);
    endfunction

    function automatic logic [11:0] f_clamp12(input logic signed [19:0] v);
        if (v < 20'sd0) begin
            f_clamp12 = '0;
        end else if (v > 20'sd4095) begin
            f_clamp12 = 12'd4095;
        end else begin
            f_clamp12 = v[11:0];
        end
    endfunction

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px   <= '0;
            r_py   <= '0;
            r_dirx <= -16'sd16384;
            r_diry <= '0;
            r_plx  <= '0;
            r_ply  <= 16'sd10813;
            r_w    <= 13'd640;
            r_h    <= 13'd480;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_PLAYER_X: r_px   <= i_cfg_data;
                REG_PLAYER_Y: r_py   <= i_cfg_data;
                REG_DIR_X:    r_dirx <= i_cfg_data;
                REG_DIR_Y:    r_diry <= i_cfg_data;
                REG_PLANE_X:  r_plx  <= i_cfg_data;
                REG_PLANE_Y:  r_ply  <= i_cfg_data;
                REG_SCREEN_W: r_w    <= i_cfg_data[12:0];
                REG_SCREEN_H: r_h    <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= start && !busy;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_dx <= 17'(i_obj_x) - 17'(r_px);
        r1_dy <= 17'(i_obj_y) - 17'(r_py);

        r2_pa <= r_diry * r1_dx;
        r2_pb <= r_dirx * r1_dy;
        r2_pc <= r_plx * r1_dy;
        r2_pd <= r_ply * r1_dx;
        r2_da <= r_plx * r_diry;
        r2_db <= r_dirx * r_ply;

        r3_nx  <= 34'(r2_pa) - 34'(r2_pb);
        r3_ny  <= 34'(r2_pc) - 34'(r2_pd);
        r3_det <= 33'(r2_da) - 33'(r2_db);

        r4_dnum  <= 48'(r3_ny) <<< 14;
        r4_cnum  <= $signed({1'b0, r_w[12:1]}) * (35'(r3_nx) + 35'(r3_ny));
        r4_hd    <= $signed({1'b0, r_h}) * r3_det;
        r4_ny640 <= 48'(r3_ny) * 48'sd640;
        r4_ny64  <= 48'(r3_ny) <<< 6;
        r4_det   <= 48'(r3_det);
        r4_ny    <= 48'(r3_ny);
        r4_zero  <= (r3_det == 33'sd0) || (r3_ny == 34'sd0);
    end

    always_comb begin
        if (r4_det > 48'sd0) begin
            n_front = r4_ny640 > r4_det;
        end else begin
            n_front = r4_ny640 < r4_det;
        end
    end

    bsp_div u_div_depth (
        .i_clk  (i_clk),
        .i_num  (f_abs(r4_dnum)),
        .i_den  (f_abs(r4_det)),
        .i_neg  (r4_dnum[47] ^ r4_det[47]),
        .o_quot (n_qd)
    );

    bsp_div u_div_center (
        .i_clk  (i_clk),
        .i_num  (f_abs(r4_cnum)),
        .i_den  (f_abs(r4_ny)),
        .i_neg  (r4_cnum[47] ^ r4_ny[47]),
        .o_quot (n_qc)
    );

    bsp_div u_div_vshift (
        .i_clk  (i_clk),
        .i_num  (f_abs(r4_hd)),
        .i_den  (f_abs(r4_ny640)),
        .i_neg  (r4_hd[47] ^ r4_ny640[47]),
        .o_quot (n_qv)
    );

    bsp_div u_div_size (
        .i_clk  (i_clk),
        .i_num  (f_abs(r4_hd)),
        .i_den  (f_abs(r4_ny64)),
        .i_neg  (1'b0),
        .o_quot (n_qs)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= QBits; i++) begin
                r_side[i] <= '0;
            end
        end else begin
            r_side[0] <= '{valid: r_v4, zero: r4_zero, front: n_front && !r4_zero};
            for (int i = 0; i < QBits; i++) begin
                r_side[i+1] <= r_side[i];
            end
        end
    end

    logic signed [15:0] n_center, n_depth, n_vshift;
    logic [14:0]        n_size;
    logic signed [19:0] n_half_sz, n_top, n_bottom, n_ledge, n_right, n_hm1, n_wm1;
    logic signed [15:0] n_ledge16;

    always_comb begin
        if (r_side[QBits].zero) begin
            n_center = 16'sd32767;
            n_depth  = '0;
            n_vshift = 16'sd32767;
            n_size   = 15'd32767;
        end else begin
            n_center = n_qc;
            n_depth  = n_qd;
            n_vshift = n_qv;
            n_size   = n_qs[14:0];
        end
        n_half_sz = 20'(n_size[14:1]);
        n_hm1     = 20'(r_h) - 20'sd1;
        n_wm1     = 20'(r_w) - 20'sd1;
        n_top     = 20'(r_h[12:1]) + 20'(n_vshift) - n_half_sz;
        n_bottom  = 20'(r_h[12:1]) + 20'(n_vshift) + n_half_sz;
        if (n_bottom >= $signed(20'(r_h))) begin
            n_bottom = n_hm1;
        end
        n_ledge = 20'(n_center) - n_half_sz;
        if (n_ledge < -20'sd32768) begin
            n_ledge16 = -16'sd32768;
        end else begin
            n_ledge16 = n_ledge[15:0];
        end
        n_right = 20'(n_center) + n_half_sz;
        if (n_right >= $signed(20'(r_w))) begin
            n_right = n_wm1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_side[QBits].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        o_center_col  <= n_center;
        o_depth       <= n_depth;
        o_vert_shift  <= n_vshift;
        o_sprite_size <= n_size;
        o_top_row     <= f_clamp12(n_top);
        o_bottom_row  <= f_clamp12(n_bottom);
        o_left_edge   <= n_ledge16;
        o_left_col    <= f_clamp12(20'(n_ledge16));
        o_right_col   <= f_clamp12(n_right);
        o_in_front    <= r_side[QBits].front;
    end

endmodule

### rtl/core/bsp_checker.sv
`timescale 1ns / 1ps
module bsp_assertions (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic               o_valid,
    input  logic signed [15:0] o_depth,
    input  logic [11:0]        o_left_col,
    input  logic signed [15:0] o_left_edge,
    input  logic               o_in_front
);

    a_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("busy raised");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##23 o_valid)
        else $error("item result missing after 23 cycles");

    a_front_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_in_front) |-> (!o_depth[15] && o_depth != 16'sd0))
        else $error("in front with non-positive depth");

    a_left_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_left_edge[15] && o_left_edge < 16'sd4096)
            |-> (o_left_col == o_left_edge[11:0]))
        else $error("left column differs from left edge");

endmodule

bind billboard_sprite_projection bsp_assertions u_bsp_assertions (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_valid     (o_valid),
    .o_depth     (o_depth),
    .o_left_col  (o_left_col),
    .o_left_edge (o_left_edge),
    .o_in_front  (o_in_front)
);

### dv/bsp_checker.sv
`timescale 1ns / 1ps
module bsp_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic signed [15:0] i_obj_x,
    input  logic signed [15:0] i_obj_y,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    input  logic               o_valid,
    input  logic signed [15:0] o_center_col,
    input  logic signed [15:0] o_depth,
    input  logic signed [15:0] o_vert_shift,
    input  logic [14:0]        o_sprite_size,
    input  logic [11:0]        o_top_row,
    input  logic [11:0]        o_bottom_row,
    input  logic [11:0]        o_left_col,
    input  logic [11:0]        o_right_col,
    input  logic signed [15:0] o_left_edge,
    input  logic               o_in_front,
    output int                 o_errors,
    output int                 o_pending,
    output int                 o_seen
);
    import bsp_pkg::*;

    typedef struct packed {
        logic [15:0] center;
        logic [15:0] depth;
        logic [15:0] vshift;
        logic [14:0] size;
        logic [11:0] top;
        logic [11:0] bottom;
        logic [11:0] left;
        logic [11:0] right;
        logic [15:0] ledge;
        logic        front;
    } t_proj;

    t_proj projections_due[$];
    logic signed [15:0] pos_x, pos_y, dir_x, dir_y, pl_x, pl_y;
    logic [12:0] scr_w, scr_h;

    function automatic longint clampv(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint absl(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic t_proj project(logic signed [15:0] ox, logic signed [15:0] oy);
        longint w, h, dx, dy, det, nx, ny, c, d, vs, sz, fr, tp, bt, le, lf, rt;
        t_proj p;
        w = scr_w;
        h = scr_h;
        dx = longint'(ox) - longint'(pos_x);
        dy = longint'(oy) - longint'(pos_y);
        det = longint'(pl_x) * dir_y - longint'(dir_x) * pl_y;
        nx = longint'(dir_y) * dx - longint'(dir_x) * dy;
        ny = longint'(pl_x) * dy - longint'(pl_y) * dx;
        if (det == 0 || ny == 0) begin
            d = 0; fr = 0; c = 32767; vs = 32767; sz = 32767;
        end else begin
            d = clampv((ny * 16384) / det, -32768, 32767);
            c = clampv(((w >>> 1) * (ny + nx)) / ny, -32768, 32767);
            vs = clampv((h * det) / (640 * ny), -32768, 32767);
            sz = clampv(absl(h * det) / absl(64 * ny), 0, 32767);
            if (det > 0) fr = (ny * 640 > det) ? 1 : 0;
            else fr = (ny * 640 < det) ? 1 : 0;
        end
        tp = clampv((h >>> 1) + vs - (sz >>> 1), 0, 4095);
        bt = (h >>> 1) + vs + (sz >>> 1);
        if (bt >= h) bt = h - 1;
        bt = clampv(bt, 0, 4095);
        le = clampv(c - (sz >>> 1), -32768, 32767);
        lf = clampv(le, 0, 4095);
        rt = c + (sz >>> 1);
        if (rt >= w) rt = w - 1;
        rt = clampv(rt, 0, 4095);
        p = '{c[15:0], d[15:0], vs[15:0], sz[14:0], tp[11:0], bt[11:0], lf[11:0],
              rt[11:0], le[15:0], fr[0]};
        return p;
    endfunction

    assign o_pending = projections_due.size();

    always @(posedge i_clk) begin
        t_proj got, want;
        if (!i_rst_n) begin
            pos_x <= 16'sd0; pos_y <= 16'sd0; dir_x <= -16'sd16384; dir_y <= 16'sd0;
            pl_x <= 16'sd0; pl_y <= 16'sd10813; scr_w <= 13'd640; scr_h <= 13'd480;
            o_errors <= 0;
            o_seen <= 0;
            projections_due.delete();
        end else begin
            if (o_valid) begin
                got = '{o_center_col, o_depth, o_vert_shift, o_sprite_size, o_top_row,
                        o_bottom_row, o_left_col, o_right_col, o_left_edge, o_in_front};
                o_seen <= o_seen + 1;
                if (projections_due.size() == 0) begin
                    $display("%0t: result with none expected, actual %h", $time, got);
                    o_errors <= o_errors + 1;
                end else begin
                    want = projections_due.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch, expected %h, actual %h", $time, want, got);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (start && !busy)
                projections_due.push_back(project(i_obj_x, i_obj_y));
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_idx))
                    REG_PLAYER_X: pos_x <= i_cfg_data;
                    REG_PLAYER_Y: pos_y <= i_cfg_data;
                    REG_DIR_X:    dir_x <= i_cfg_data;
                    REG_DIR_Y:    dir_y <= i_cfg_data;
                    REG_PLANE_X:  pl_x <= i_cfg_data;
                    REG_PLANE_Y:  pl_y <= i_cfg_data;
                    REG_SCREEN_W: scr_w <= i_cfg_data[12:0];
                    REG_SCREEN_H: scr_h <= i_cfg_data[12:0];
                    default: ;
                endcase
            end
        end
    end
endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import bsp_pkg::*;

    logic i_clk = 1'b0, i_rst_n = 1'b0;
    logic start = 1'b0, busy;
    logic signed [15:0] i_obj_x = '0, i_obj_y = '0;
    logic i_cfg_we = 1'b0;
    logic [2:0] i_cfg_idx = '0;
    logic [15:0] i_cfg_data = '0;
    logic o_valid, o_in_front;
    logic signed [15:0] o_center_col, o_depth, o_vert_shift, o_left_edge;
    logic [14:0] o_sprite_size;
    logic [11:0] o_top_row, o_bottom_row, o_left_col, o_right_col;
    int errors, pending, seen, cycles, idle_pct, items;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    billboard_sprite_projection u_top (.*);

    bsp_checker u_chk (.*, .o_errors(errors), .o_pending(pending), .o_seen(seen));

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic cfg_write(t_reg_idx idx, logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (pending != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
    endtask

    task automatic send(logic [15:0] x, logic [15:0] y);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start <= 1'b1;
        i_obj_x <= x;
        i_obj_y <= y;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
        items++;
    endtask

    task automatic random_view();
        cfg_write(REG_PLAYER_X, 16'($urandom));
        cfg_write(REG_PLAYER_Y, 16'($urandom));
        cfg_write(REG_DIR_X, 16'($urandom));
        cfg_write(REG_DIR_Y, 16'($urandom));
        cfg_write(REG_PLANE_X, 16'($urandom));
        cfg_write(REG_PLANE_Y, 16'($urandom));
        cfg_write(REG_SCREEN_W, 16'($urandom_range(1, 4096)));
        cfg_write(REG_SCREEN_H, 16'($urandom_range(1, 4096)));
    endtask

    initial begin
        int pcts[4];
        logic [15:0] v;
        pcts = '{0, 52, 21, 52};
        items = 0;
        idle_pct = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        send(16'h0000, 16'h0000);
        send(16'h7fff, 16'h7fff);
        send(16'h8000, 16'h8000);
        send(16'h7fff, 16'h8000);
        send(16'h0100, 16'h0000);
        send(16'h0000, 16'h0100);
        send(16'hff00, 16'h0019);
        send(16'h001a, 16'h0000);
        start <= 1'b0;
        drain();
        cfg_write(REG_DIR_X, 16'h0000);
        cfg_write(REG_PLANE_Y, 16'h0000);
        cfg_write(REG_SCREEN_W, 16'h0000);
        send(16'h0100, 16'h0200);
        start <= 1'b0;
        drain();
        cfg_write(REG_DIR_X, 16'h8000);
        cfg_write(REG_PLANE_Y, 16'h7fff);
        cfg_write(REG_SCREEN_W, 16'h1000);
        cfg_write(REG_SCREEN_H, 16'h0001);
        send(16'h8000, 16'h7fff);
        send(16'h0001, 16'hffff);
        start <= 1'b0;
        drain();
        for (int ph = 0; ph < 16; ph++) begin
            idle_pct = pcts[ph % 4];
            if (ph % 5 == 4) begin
                cfg_write(REG_PLAYER_X, 16'h8000);
                cfg_write(REG_PLAYER_Y, 16'h7fff);
                cfg_write(REG_DIR_X, 16'h7fff);
                cfg_write(REG_DIR_Y, 16'h8000);
                cfg_write(REG_PLANE_X, 16'h8000);
                cfg_write(REG_PLANE_Y, 16'h7fff);
                cfg_write(REG_SCREEN_W, 16'd1);
                cfg_write(REG_SCREEN_H, 16'd4096);
            end else begin
                random_view();
            end
            for (int k = 0; k < 68; k++) begin
                v = 16'($urandom);
                if ($urandom_range(3) == 0) send(16'($urandom), 16'($urandom));
                else send({{8{v[15]}}, v[7:0]}, 16'($urandom_range(65535)));
            end
            start <= 1'b0;
            drain();
        end
        $display("Covered %0d sprites over 19 view settings, %0d results checked.",
                 items, seen);
        if (errors == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
